// ===== hdl/jgpg_pkg.sv =====
// Shared constants, types and the quarter-wave sine table for the grating pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package jgpg_pkg;

  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int CENTRE_X     = IMAGE_WIDTH / 2;
  localparam int CENTRE_Y     = IMAGE_HEIGHT / 2;
  localparam int CENTRE_MAX   = (CENTRE_X > CENTRE_Y) ? CENTRE_X : CENTRE_Y;
  localparam int DELTA_SPAN   = (CENTRE_MAX > 256) ? CENTRE_MAX : 256;

  localparam int COORD_W  = 8;
  localparam int JITTER_W = 16;
  localparam int RADIUS_W = 13;
  localparam int TRIG_W   = 16;
  localparam int LEVEL_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DELTA_W = $clog2(DELTA_SPAN) + 1;
  localparam int SQ_W    = 2 * DELTA_W - 1;
  localparam int DIST_W  = SQ_W + 1 + 8;
  localparam int RSQ_W   = 2 * RADIUS_W;
  localparam int CMP_W   = (DIST_W > RSQ_W) ? DIST_W : RSQ_W;
  localparam int SHIFT_W = DELTA_W + 8;
  localparam int U_W     = ((SHIFT_W > JITTER_W) ? SHIFT_W : JITTER_W) + 1;
  localparam int PROD_W  = U_W + TRIG_W;
  localparam int PROJ_W  = PROD_W + 1;
  localparam int CYC_W   = 38;
  localparam int PHASE_LSB = 22;
  localparam int PHASE_W   = 16;

  localparam int SINE_W    = 16;
  localparam int MAG_W     = 18;
  localparam int FACTOR_W  = 19;
  localparam int FULL_SCALE = 32768;
  localparam int HALF_LSB   = 16384;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIRCLE_RADIUS    = 3'd0,
    CFG_COS_ORIENTATION  = 3'd1,
    CFG_SIN_ORIENTATION  = 3'd2,
    CFG_CYCLES_PER_PIXEL = 3'd3,
    CFG_RED_BASE         = 3'd4,
    CFG_GREEN_BASE       = 3'd5,
    CFG_BLUE_BASE        = 3'd6,
    CFG_CONTRAST_LEVEL   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]      disc_radius;
    logic signed [TRIG_W-1:0] cos_orientation;
    logic signed [TRIG_W-1:0] sin_orientation;
    logic [LEVEL_W-1:0]       cycles_per_pixel;
    logic [LEVEL_W-1:0]       red_base;
    logic [LEVEL_W-1:0]       green_base;
    logic [LEVEL_W-1:0]       blue_base;
    logic [LEVEL_W-1:0]       contrast_level;
  } cfg_t;

  typedef struct packed {
    logic signed [U_W-1:0] u;
    logic signed [U_W-1:0] v;
  } mid_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } out_item_t;

  function automatic logic [SINE_W-1:0] quarter_sine(input logic [5:0] idx);
    logic [SINE_W-1:0] val;
    unique case (idx)
      6'd0:  val = 16'd0;
      6'd1:  val = 16'd1608;
      6'd2:  val = 16'd3212;
      6'd3:  val = 16'd4808;
      6'd4:  val = 16'd6393;
      6'd5:  val = 16'd7962;
      6'd6:  val = 16'd9512;
      6'd7:  val = 16'd11039;
      6'd8:  val = 16'd12540;
      6'd9:  val = 16'd14010;
      6'd10: val = 16'd15447;
      6'd11: val = 16'd16846;
      6'd12: val = 16'd18205;
      6'd13: val = 16'd19520;
      6'd14: val = 16'd20788;
      6'd15: val = 16'd22006;
      6'd16: val = 16'd23170;
      6'd17: val = 16'd24279;
      6'd18: val = 16'd25330;
      6'd19: val = 16'd26320;
      6'd20: val = 16'd27246;
      6'd21: val = 16'd28106;
      6'd22: val = 16'd28899;
      6'd23: val = 16'd29622;
      6'd24: val = 16'd30274;
      6'd25: val = 16'd30853;
      6'd26: val = 16'd31357;
      6'd27: val = 16'd31786;
      6'd28: val = 16'd32138;
      6'd29: val = 16'd32413;
      6'd30: val = 16'd32610;
      6'd31: val = 16'd32729;
      default: val = 16'd32768;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/jgpg_queue.sv =====
// Short queue of classified pixels between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module jgpg_queue
  import jgpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire mid_item_t push_item,
  input  wire logic      pop,
  output logic           empty,
  output mid_item_t      head_item
);

  mid_item_t          store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/jgpg_front.sv =====
// Front part: takes pixels, tests them against the disc and applies the chosen jitter.
`timescale 1ns / 1ps
`default_nettype none
module jgpg_front
  import jgpg_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [COORD_W-1:0]         in_pixel_x,
  input  wire logic [COORD_W-1:0]         in_pixel_y,
  input  wire logic signed [JITTER_W-1:0] in_jitter_inside,
  input  wire logic signed [JITTER_W-1:0] in_jitter_outside,
  input  wire logic [RADIUS_W-1:0]        disc_radius,
  output logic                            q_push,
  input  wire logic                       q_full,
  output mid_item_t                       q_item
);

  logic                        valid_r, valid_nxt;
  logic                        advance;
  logic signed [DELTA_W-1:0]   dx, dy;
  logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
  logic signed [SHIFT_W-1:0]   dx_shift, dy_shift;
  logic [SQ_W-1:0]             sqx_r, sqy_r;
  logic [RSQ_W-1:0]            rsq_r;
  logic signed [U_W-1:0]       u_in_r, v_in_r, u_out_r, v_out_r;
  logic [DIST_W-1:0]           dist_sq;
  logic                        in_disc;

  assign advance = !valid_r || !q_full;
  assign in_full = !advance;

  assign dx       = signed'(DELTA_W'(in_pixel_x) - DELTA_W'(CENTRE_X));
  assign dy       = signed'(DELTA_W'(in_pixel_y) - DELTA_W'(CENTRE_Y));
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign dx_shift = {dx, 8'b0};
  assign dy_shift = {dy, 8'b0};

  assign valid_nxt = advance ? in_push : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sqx_r   <= sqx_full[SQ_W-1:0];
      sqy_r   <= sqy_full[SQ_W-1:0];
      rsq_r   <= RSQ_W'(disc_radius) * RSQ_W'(disc_radius);
      u_in_r  <= U_W'(dx_shift) + U_W'(in_jitter_inside);
      v_in_r  <= U_W'(dy_shift) + U_W'(in_jitter_inside);
      u_out_r <= U_W'(dx_shift) + U_W'(in_jitter_outside);
      v_out_r <= U_W'(dy_shift) + U_W'(in_jitter_outside);
    end
  end

  always_comb begin
    dist_sq  = (DIST_W'(sqx_r) + DIST_W'(sqy_r)) << 8;
    in_disc  = CMP_W'(dist_sq) < CMP_W'(rsq_r);
    q_push   = valid_r;
    q_item.u = in_disc ? u_in_r : u_out_r;
    q_item.v = in_disc ? v_in_r : v_out_r;
  end

endmodule
`default_nettype wire

// ===== hdl/jgpg_back.sv =====
// Back part: projection, phase, sine, modulation and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module jgpg_back
  import jgpg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire mid_item_t          q_head,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [LEVEL_W-1:0]      out_red_value,
  output logic [LEVEL_W-1:0]      out_green_value,
  output logic [LEVEL_W-1:0]      out_blue_value
);

  function automatic logic [LEVEL_W-1:0] channel(input logic [LEVEL_W-1:0] base,
                                                 input logic signed [FACTOR_W-1:0] factor);
    logic [34:0] prod;
    logic [19:0] val;
    logic [LEVEL_W-1:0] res;
    prod = 35'(base) * 35'(factor[FACTOR_W-2:0]) + 35'(HALF_LSB);
    val  = prod[34:15];
    if (factor <= 0) begin
      res = '0;
    end else if (val > 20'(16'hFFFF)) begin
      res = '1;
    end else begin
      res = val[LEVEL_W-1:0];
    end
    return res;
  endfunction

  logic                       advance;
  logic                       v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [PROD_W-1:0]   p_cos_r, p_sin_r;
  logic signed [PROJ_W-1:0]   sum_r;
  logic [CYC_W-1:0]           cyc_low;
  logic [CYC_W+LEVEL_W-1:0]   cyc_prod;
  logic [PHASE_W-1:0]         phase_r;
  logic [13:0]                wave_pos;
  logic [14:0]                quarter_pos;
  logic [SINE_W-1:0]          lo_val, hi_val, span, interp;
  logic [25:0]                interp_prod;
  logic [SINE_W-1:0]          s_mag_r;
  logic                       neg_r;
  logic [32:0]                mag_full;
  logic [MAG_W-1:0]           mag;
  logic signed [FACTOR_W-1:0] factor_r;

  out_item_t                  fifo_r [QUEUE_DEPTH];
  out_item_t                  fifo_in;
  logic [QPTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]          count_r;
  logic                       out_full, fifo_push, fifo_pop;

  assign out_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign out_empty = (count_r == '0);
  assign advance   = !(v5_r && out_full);
  assign q_pop     = advance && !q_empty;
  assign fifo_push = v5_r && advance;
  assign fifo_pop  = out_pop && !out_empty;

  always_comb begin
    cyc_low     = CYC_W'(sum_r);
    cyc_prod    = (CYC_W + LEVEL_W)'(cyc_low) * (CYC_W + LEVEL_W)'(cfg.cycles_per_pixel);
    wave_pos    = phase_r[13:0];
    quarter_pos = phase_r[14] ? 15'(FULL_SCALE / 2) - 15'(wave_pos) : 15'(wave_pos);
    lo_val      = quarter_sine(quarter_pos[14:9]);
    hi_val      = quarter_sine(quarter_pos[14:9] + 6'd1);
    span        = hi_val - lo_val;
    interp_prod = 26'(span) * 26'(quarter_pos[8:0]) + 26'd256;
    interp      = quarter_pos[14] ? SINE_W'(FULL_SCALE) : lo_val + interp_prod[24:9];
    mag_full    = 33'(cfg.contrast_level) * 33'(s_mag_r) + 33'(HALF_LSB);
    mag         = mag_full[32:15];
    fifo_in.red   = channel(cfg.red_base, factor_r);
    fifo_in.green = channel(cfg.green_base, factor_r);
    fifo_in.blue  = channel(cfg.blue_base, factor_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (advance) begin
      v1_r <= !q_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_cos_r  <= q_head.u * cfg.cos_orientation;
      p_sin_r  <= q_head.v * cfg.sin_orientation;
      sum_r    <= PROJ_W'(p_cos_r) + PROJ_W'(p_sin_r);
      phase_r  <= cyc_prod[PHASE_LSB +: PHASE_W];
      s_mag_r  <= interp;
      neg_r    <= phase_r[15];
      factor_r <= neg_r ? signed'(FACTOR_W'(FULL_SCALE) + FACTOR_W'(mag))
                        : signed'(FACTOR_W'(FULL_SCALE) - FACTOR_W'(mag));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (fifo_push && !fifo_pop) begin
        count_r <= count_r + 1'b1;
      end else if (fifo_pop && !fifo_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_r[wr_ptr_r] <= fifo_in;
    end
  end

  assign out_red_value   = fifo_r[rd_ptr_r].red;
  assign out_green_value = fifo_r[rd_ptr_r].green;
  assign out_blue_value  = fifo_r[rd_ptr_r].blue;

endmodule
`default_nettype wire

// ===== hdl/jittered_grating_pixel_generator_core.sv =====
// Top level of the jittered grating pixel generator: configuration registers and the two parts.
`timescale 1ns / 1ps
`default_nettype none
// The generator takes one pixel transfer per clock and returns one colour transfer per pixel,
// in order. A pixel passes an input register stage, a four-entry queue, five pipelined
// arithmetic stages (the two projection multipliers, their sum, the phase multiplier, the
// interpolated sine lookup and the contrast multiplier) and a four-entry result queue before
// its result is available. The rate of one pixel per clock holds as long as results are popped;
// each part stalls on its own when the queue after it fills.
// Configuration must only be written while no pixel is in flight.
module jittered_grating_pixel_generator_core
  import jgpg_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic [COORD_W-1:0]         in_pixel_x,
  input  wire logic [COORD_W-1:0]         in_pixel_y,
  input  wire logic signed [JITTER_W-1:0] in_jitter_inside,
  input  wire logic signed [JITTER_W-1:0] in_jitter_outside,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic [LEVEL_W-1:0]              out_red_value,
  output logic [LEVEL_W-1:0]              out_green_value,
  output logic [LEVEL_W-1:0]              out_blue_value,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      q_push, q_full, q_pop, q_empty;
  mid_item_t q_item, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CIRCLE_RADIUS:    cfg_nxt.disc_radius      = cfg_data[RADIUS_W-1:0];
        CFG_COS_ORIENTATION:  cfg_nxt.cos_orientation  = signed'(cfg_data);
        CFG_SIN_ORIENTATION:  cfg_nxt.sin_orientation  = signed'(cfg_data);
        CFG_CYCLES_PER_PIXEL: cfg_nxt.cycles_per_pixel = cfg_data;
        CFG_RED_BASE:         cfg_nxt.red_base         = cfg_data;
        CFG_GREEN_BASE:       cfg_nxt.green_base       = cfg_data;
        CFG_BLUE_BASE:        cfg_nxt.blue_base        = cfg_data;
        CFG_CONTRAST_LEVEL:   cfg_nxt.contrast_level   = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disc_radius      <= 13'd1024;
      cfg_r.cos_orientation  <= 16'sd16384;
      cfg_r.sin_orientation  <= 16'sd0;
      cfg_r.cycles_per_pixel <= 16'd2048;
      cfg_r.red_base         <= 16'd32768;
      cfg_r.green_base       <= 16'd32768;
      cfg_r.blue_base        <= 16'd32768;
      cfg_r.contrast_level   <= 16'd32768;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jgpg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel_x        (in_pixel_x),
    .in_pixel_y        (in_pixel_y),
    .in_jitter_inside  (in_jitter_inside),
    .in_jitter_outside (in_jitter_outside),
    .disc_radius       (cfg_r.disc_radius),
    .q_push            (q_push),
    .q_full            (q_full),
    .q_item            (q_item)
  );

  jgpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .push_item (q_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  jgpg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_head          (q_head),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_red_value   (out_red_value),
    .out_green_value (out_green_value),
    .out_blue_value  (out_blue_value)
  );

endmodule
`default_nettype wire
